// ===== design/h264fu_pkg.sv =====
// types, constants and helpers for the h.264 fu-a rtp fragmenter
// no dependencies; used by h264_fua_rtp_fragmenter_unit

package h264fu_pkg;

  localparam logic [7:0]  FU_NRI_MASK   = 8'hE0;
  localparam logic [7:0]  FU_A_TYPE     = 8'd28;
  localparam logic [7:0]  FU_START_BIT  = 8'h80;
  localparam logic [7:0]  FU_END_BIT    = 8'h40;
  localparam logic [7:0]  FU_TYPE_MASK  = 8'h1F;

  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1400;
  localparam logic [3:0]  HEADER_LENGTH_RST = 4'd12;
  localparam logic [15:0] MIN_PAYLOAD       = 16'd3;

  // configuration register indexes
  localparam logic REG_MAX_PAYLOAD   = 1'b0;
  localparam logic REG_HEADER_LENGTH = 1'b1;

  // which byte of a result bundle is on the output
  typedef enum logic [1:0] {
    PH_IND,
    PH_HDR,
    PH_DATA
  } phase_t;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    sat16 = v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== design/h264_fua_rtp_fragmenter_unit.sv =====
// h.264 nal to rtp payload fragmenter (single nal unit and fu-a packets)
// depends on h264fu_pkg
//
// usage: one nal byte per input transfer (in_valid / in_stall); nal size,
// timestamp and frame kind are sampled on the nal's first byte. each result
// transfer (out_valid / out_stall) carries one payload byte with packet start,
// end, size (header bytes included), marker, timestamp, kind and item_last.
// config writes (cfg_valid / cfg_ready, ready always high): index 0 is
// max_payload, index 1 header_length; both are latched at each nal's first
// byte.
// path: an input byte is held in the input register, then in the result bundle register.
// throughput: one result per cycle while out_stall is low. an input byte gives one result, the first
// byte of a fragmented nal two (fu indicator, fu header), and the first data
// byte of each later fragment three; the output side sets the pace, so such
// a byte holds the input until all its results have been taken.
// structure: input register, then single-pass packetizing logic into a result
// bundle register that is drained one byte per cycle (while out_stall is low) by a small phase counter.
// reset: no nal in progress, registers to 1400 and 12, both channels empty.
// a stall on the output holds the bundle; the input register still takes one
// more byte before in_stall rises.

module h264_fua_rtp_fragmenter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [23:0] in_nal_size,
  input  logic [31:0] in_stamp,
  input  logic [7:0]  in_frame_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_packet_start,
  output logic        out_packet_end,
  output logic [15:0] out_packet_size,
  output logic        out_marker,
  output logic [31:0] out_stamp,
  output logic [7:0]  out_kind,
  output logic        out_item_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // config
  logic [15:0] max_payload_r;
  logic [3:0]  header_length_r;

  // input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic [23:0] in_size_r;
  logic [31:0] in_stamp_r;
  logic [7:0]  in_kind_r;

  // nal state
  logic [23:0] nal_left_r, nal_left_nxt;
  logic [15:0] packet_left_r, packet_left_nxt;
  logic        fragment_mode_r, fragment_mode_nxt;
  logic [7:0]  fu_indicator_r, fu_indicator_nxt;
  logic [4:0]  fu_nal_type_r, fu_nal_type_nxt;
  logic        first_fragment_r, first_fragment_nxt;
  logic [31:0] held_stamp_r, held_stamp_nxt;
  logic [7:0]  held_kind_r, held_kind_nxt;
  logic [15:0] cur_size_r, cur_size_nxt;
  logic        cur_marker_r, cur_marker_nxt;
  logic [15:0] lim_r, lim_nxt;
  logic [3:0]  hdr_r, hdr_nxt;

  // result bundle
  logic                bnd_valid_r;
  logic                bnd_has_fu_r, bnd_has_fu_nxt;
  logic                bnd_has_data_r, bnd_has_data_nxt;
  logic                bnd_dstart_r, bnd_dstart_nxt;
  logic                bnd_dend_r, bnd_dend_nxt;
  logic [7:0]          bnd_ind_r;
  logic [7:0]          bnd_hb_r, bnd_hb_nxt;
  logic [7:0]          bnd_data_r;
  logic [15:0]         bnd_size_r;
  logic                bnd_marker_r;
  logic [31:0]         bnd_stamp_r;
  logic [7:0]          bnd_kind_r;
  h264fu_pkg::phase_t  phase_r, phase_nxt;

  logic move;
  logic in_xfer;
  logic out_xfer;
  logic last_phase;
  logic bnd_done;

  // single-pass datapath signals
  logic        start;
  logic [23:0] size24;
  logic [15:0] lim_new;
  logic [15:0] lim_use;
  logic [3:0]  hdr_use;
  logic [7:0]  ind_use;
  logic [4:0]  type_use;
  logic        first_use;
  logic [23:0] rest;
  logic [15:0] lim_m2;
  logic        of_final;
  logic [15:0] of_pl;
  logic [15:0] of_size;
  logic [7:0]  of_hb;
  logic [15:0] pl_base;

  assign cfg_ready = 1'b1;

  assign last_phase = (phase_r == h264fu_pkg::PH_DATA) ||
                      ((phase_r == h264fu_pkg::PH_HDR) && !bnd_has_data_r);
  assign out_xfer   = bnd_valid_r && !out_stall;
  assign bnd_done   = out_xfer && last_phase;
  assign move       = in_valid_r && (!bnd_valid_r || bnd_done);
  assign in_stall   = in_valid_r && !move;
  assign in_xfer    = in_valid && !in_stall;

  // open-fragment arithmetic, shared by nal start and fragment boundaries
  always_comb begin
    start     = (nal_left_r == 24'd0);
    size24    = (in_size_r == 24'd0) ? 24'd1 : in_size_r;
    lim_new   = (max_payload_r < h264fu_pkg::MIN_PAYLOAD) ? h264fu_pkg::MIN_PAYLOAD
                                                           : max_payload_r;
    lim_use   = start ? lim_new : lim_r;
    hdr_use   = start ? header_length_r : hdr_r;
    ind_use   = start ? ((in_byte_r & h264fu_pkg::FU_NRI_MASK) | h264fu_pkg::FU_A_TYPE)
                      : fu_indicator_r;
    type_use  = start ? in_byte_r[4:0] : fu_nal_type_r;
    first_use = start ? 1'b1 : first_fragment_r;
    rest      = start ? (size24 - 24'd1) : nal_left_r;
    lim_m2    = lim_use - 16'd2;
    of_final  = (rest <= {8'd0, lim_m2});
    of_pl     = of_final ? rest[15:0] : lim_m2;
    of_size   = of_final ? h264fu_pkg::sat16({13'd0, hdr_use} + 17'd2 + rest[16:0])
                         : h264fu_pkg::sat16({13'd0, hdr_use} + {1'b0, lim_use});
    of_hb     = {3'd0, type_use} |
                (first_use ? h264fu_pkg::FU_START_BIT : 8'd0) |
                (of_final ? h264fu_pkg::FU_END_BIT : 8'd0);
  end

  // next nal state and result bundle
  always_comb begin
    nal_left_nxt       = nal_left_r;
    packet_left_nxt    = packet_left_r;
    fragment_mode_nxt  = fragment_mode_r;
    fu_indicator_nxt   = fu_indicator_r;
    fu_nal_type_nxt    = fu_nal_type_r;
    first_fragment_nxt = first_fragment_r;
    held_stamp_nxt     = held_stamp_r;
    held_kind_nxt      = held_kind_r;
    cur_size_nxt       = cur_size_r;
    cur_marker_nxt     = cur_marker_r;
    lim_nxt            = lim_r;
    hdr_nxt            = hdr_r;
    bnd_has_fu_nxt     = 1'b0;
    bnd_has_data_nxt   = 1'b1;
    bnd_dstart_nxt     = 1'b0;
    bnd_dend_nxt       = 1'b0;
    bnd_hb_nxt         = of_hb;
    pl_base            = packet_left_r;
    if (start) begin
      held_stamp_nxt = in_stamp_r;
      held_kind_nxt  = in_kind_r;
      lim_nxt        = lim_new;
      hdr_nxt        = header_length_r;
      nal_left_nxt   = size24 - 24'd1;
      if (size24 <= {8'd0, lim_new}) begin
        fragment_mode_nxt = 1'b0;
        packet_left_nxt   = size24[15:0] - 16'd1;
        cur_size_nxt      = h264fu_pkg::sat16({1'b0, size24[15:0]} + {13'd0, header_length_r});
        cur_marker_nxt    = 1'b1;
        bnd_dstart_nxt    = 1'b1;
        bnd_dend_nxt      = (size24 == 24'd1);
      end else begin
        fragment_mode_nxt  = 1'b1;
        fu_indicator_nxt   = ind_use;
        fu_nal_type_nxt    = type_use;
        first_fragment_nxt = 1'b0;
        packet_left_nxt    = of_pl;
        cur_size_nxt       = of_size;
        cur_marker_nxt     = of_final;
        bnd_has_fu_nxt     = 1'b1;
        bnd_has_data_nxt   = 1'b0;
      end
    end else if (!fragment_mode_r) begin
      nal_left_nxt    = nal_left_r - 24'd1;
      packet_left_nxt = (packet_left_r == 16'd0) ? 16'd0 : packet_left_r - 16'd1;
      bnd_dend_nxt    = (packet_left_r <= 16'd1);
    end else begin
      if (packet_left_r == 16'd0) begin
        pl_base            = of_pl;
        cur_size_nxt       = of_size;
        cur_marker_nxt     = of_final;
        first_fragment_nxt = 1'b0;
        bnd_has_fu_nxt     = 1'b1;
      end
      nal_left_nxt    = nal_left_r - 24'd1;
      packet_left_nxt = pl_base - 16'd1;
      bnd_dend_nxt    = (pl_base == 16'd1);
    end
  end

  // output phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (move) begin
      phase_nxt = bnd_has_fu_nxt ? h264fu_pkg::PH_IND : h264fu_pkg::PH_DATA;
    end else if (out_xfer) begin
      unique case (phase_r)
        h264fu_pkg::PH_IND:  phase_nxt = h264fu_pkg::PH_HDR;
        h264fu_pkg::PH_HDR:  phase_nxt = h264fu_pkg::PH_DATA;
        h264fu_pkg::PH_DATA: phase_nxt = h264fu_pkg::PH_DATA;
        default:             phase_nxt = h264fu_pkg::PH_DATA;
      endcase
    end
  end

  // output selection
  always_comb begin
    out_valid        = bnd_valid_r;
    out_packet_size  = bnd_size_r;
    out_marker       = bnd_marker_r;
    out_stamp        = bnd_stamp_r;
    out_kind         = bnd_kind_r;
    out_item_last    = last_phase;
    unique case (phase_r)
      h264fu_pkg::PH_IND: begin
        out_byte         = bnd_ind_r;
        out_packet_start = 1'b1;
        out_packet_end   = 1'b0;
      end
      h264fu_pkg::PH_HDR: begin
        out_byte         = bnd_hb_r;
        out_packet_start = 1'b0;
        out_packet_end   = 1'b0;
      end
      h264fu_pkg::PH_DATA: begin
        out_byte         = bnd_data_r;
        out_packet_start = bnd_dstart_r;
        out_packet_end   = bnd_dend_r;
      end
      default: begin
        out_byte         = bnd_data_r;
        out_packet_start = 1'b0;
        out_packet_end   = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r    <= h264fu_pkg::MAX_PAYLOAD_RST;
      header_length_r  <= h264fu_pkg::HEADER_LENGTH_RST;
      in_valid_r       <= 1'b0;
      bnd_valid_r      <= 1'b0;
      phase_r          <= h264fu_pkg::PH_DATA;
      nal_left_r       <= 24'd0;
      packet_left_r    <= 16'd0;
      fragment_mode_r  <= 1'b0;
      first_fragment_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          h264fu_pkg::REG_MAX_PAYLOAD:   max_payload_r   <= cfg_data;
          h264fu_pkg::REG_HEADER_LENGTH: header_length_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (move) begin
        in_valid_r <= 1'b0;
      end
      if (move) begin
        bnd_valid_r <= 1'b1;
      end else if (bnd_done) begin
        bnd_valid_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      if (move) begin
        nal_left_r       <= nal_left_nxt;
        packet_left_r    <= packet_left_nxt;
        fragment_mode_r  <= fragment_mode_nxt;
        first_fragment_r <= first_fragment_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r  <= in_data_byte;
      in_size_r  <= in_nal_size;
      in_stamp_r <= in_stamp;
      in_kind_r  <= in_frame_kind;
    end
    if (move) begin
      fu_indicator_r <= fu_indicator_nxt;
      fu_nal_type_r  <= fu_nal_type_nxt;
      held_stamp_r   <= held_stamp_nxt;
      held_kind_r    <= held_kind_nxt;
      cur_size_r     <= cur_size_nxt;
      cur_marker_r   <= cur_marker_nxt;
      lim_r          <= lim_nxt;
      hdr_r          <= hdr_nxt;
      bnd_has_fu_r   <= bnd_has_fu_nxt;
      bnd_has_data_r <= bnd_has_data_nxt;
      bnd_dstart_r   <= bnd_dstart_nxt;
      bnd_dend_r     <= bnd_dend_nxt;
      bnd_ind_r      <= ind_use;
      bnd_hb_r       <= bnd_hb_nxt;
      bnd_data_r     <= in_byte_r;
      bnd_size_r     <= cur_size_nxt;
      bnd_marker_r   <= cur_marker_nxt;
      bnd_stamp_r    <= held_stamp_nxt;
      bnd_kind_r     <= held_kind_nxt;
    end
  end

`ifndef SYNTHESIS
  // packet byte count is empty whenever the nal byte count has run out
  a_left_align: assert property (@(posedge clk) disable iff (!rst_n)
    (nal_left_r == 24'd0) |-> (packet_left_r == 16'd0))
    else $error("packet bytes left at nal end");

  // fu indicator transfer is always followed by the fu header
  a_ind_then_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && (phase_r == h264fu_pkg::PH_IND)) |=>
      (out_valid && (phase_r == h264fu_pkg::PH_HDR)))
    else $error("fu header missing after indicator");

  // fu indicator carries type 28
  a_ind_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (phase_r == h264fu_pkg::PH_IND)) |->
      (out_byte[4:0] == h264fu_pkg::FU_A_TYPE[4:0]))
    else $error("bad fu indicator type");

  // every packet holds at least one payload byte beyond its header
  a_size_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_packet_size > {12'd0, hdr_r}))
    else $error("packet size too small");

  // input stalls only while the input register is occupied
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("stall with empty input register");
`endif

endmodule
